// ----- rtl/pft_pkg.sv -----
// Package for the physical frame table: operation and status codes,
// controller states, the frame memory entry and the free search result.
// No dependencies.
package pft_pkg;

	localparam int unsigned FRAME_IDX_W = 8;
	localparam int unsigned COUNT_W     = 7;
	localparam int unsigned OWNER_W     = 16;
	localparam int unsigned PAGE_W      = 52;
	localparam int unsigned CHOSEN_W    = 6;
	localparam int unsigned STATUS_W    = 2;

	typedef enum logic [2:0] {
		OP_ALLOC   = 3'd0,
		OP_REPLACE = 3'd1,
		OP_RELEASE = 3'd2,
		OP_MARK    = 3'd3,
		OP_READ    = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_INVALID = 2'd1,
		STAT_FULL    = 2'd2
	} status_t;

	typedef enum logic {
		CTL_IDLE = 1'b0,
		CTL_EXEC = 1'b1
	} ctl_state_t;

	typedef struct packed {
		logic [OWNER_W-1:0] owner;
		logic [PAGE_W-1:0]  page;
		logic               dirty;
		logic               referenced;
	} entry_t;

	typedef struct packed {
		logic                   found;
		logic [FRAME_IDX_W-1:0] index;
	} search_res_t;

endpackage

// ----- rtl/pft_frame_ram.sv -----
// Owner, page and access mark store of the frame table: one write port,
// one read port, registered read data. Depends on pft_pkg for the entry type.
module pft_frame_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic                  clk,
	input  logic                  wen,
	input  logic [AW-1:0]         waddr,
	input  pft_pkg::entry_t       wdata,
	input  logic                  ren,
	input  logic [AW-1:0]         raddr,
	output pft_pkg::entry_t       rdata
);

	pft_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ren) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/pft_free_search.sv -----
// Lowest free frame search: groups of sixteen frames are encoded and
// registered at load, then the lowest group with a free frame is picked.
// Depends on pft_pkg for the search result type and widths.
module pft_free_search #(
	parameter int unsigned FRAMES = 64
) (
	input  logic                          clk,
	input  logic                          load,
	input  logic [FRAMES-1:0]             occ,
	input  logic [pft_pkg::COUNT_W-1:0]   count,
	output pft_pkg::search_res_t          result
);

	localparam int unsigned GW = 16;
	localparam int unsigned NG = (FRAMES + GW - 1) / GW;

	logic [NG-1:0] grp_found_d;
	logic [3:0]    grp_first_d [NG];
	logic [NG-1:0] grp_found_s1;
	logic [3:0]    grp_first_s1 [NG];

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_found_d[g] = 1'b0;
			grp_first_d[g] = '0;
			for (int j = GW - 1; j >= 0; j--) begin
				if ((g * GW + j) < FRAMES) begin
					if (!occ[g * GW + j] && ((g * GW + j) < int'(count))) begin
						grp_found_d[g] = 1'b1;
						grp_first_d[g] = 4'(j);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_found_s1 <= grp_found_d;
			for (int g = 0; g < NG; g++) begin
				grp_first_s1[g] <= grp_first_d[g];
			end
		end
	end

	always_comb begin
		result = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_found_s1[g]) begin
				result.found = 1'b1;
				result.index = pft_pkg::FRAME_IDX_W'(g * GW) +
					pft_pkg::FRAME_IDX_W'(grp_first_s1[g]);
			end
		end
	end

endmodule

// ----- rtl/physical_frame_table.sv -----
// Physical frame table top level: item channels, APB register port, frame
// flags, controller and output register.
// Depends on pft_pkg, pft_frame_ram and pft_free_search.
//
// Usage:
//   An item (operation, frame_index, owner_id, page_number, write_access) is
//   taken on in_valid & in_ready. Each item gives exactly one result item
//   (status, chosen_frame, frame fields, free_frames) on out_valid/out_ready.
//   In the accept cycle the block reads the frame memory and registers the
//   per-group free search; in the decision cycle, once the output register
//   is free, it decides, writes the memory and flags, and loads the output
//   register, which raises out_valid. A new item is taken only once the
//   previous item's decision is done, as the memory read data is registered.
//   The output register holds a result while the receiver stalls, and the
//   next item is still taken; its decision cycle waits until that result
//   has been taken.
//   Reset, or a write of frames_in_use at addresses 0 to 3, frees every
//   frame and sets the free count to the managed frame count at once; no
//   clearing pass is needed: a free frame reads as owner -1 and page 0.
module physical_frame_table #(
	parameter int unsigned FRAMES = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [2:0]                       paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	// input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [2:0]                       operation,
	input  logic [pft_pkg::FRAME_IDX_W-1:0]  frame_index,
	input  logic signed [pft_pkg::OWNER_W-1:0] owner_id,
	input  logic [pft_pkg::PAGE_W-1:0]       page_number,
	input  logic                             write_access,
	// output channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [pft_pkg::STATUS_W-1:0]     status,
	output logic [pft_pkg::CHOSEN_W-1:0]     chosen_frame,
	output logic                             frame_occupied,
	output logic                             frame_dirty,
	output logic                             frame_referenced,
	output logic signed [pft_pkg::OWNER_W-1:0] frame_owner,
	output logic [pft_pkg::PAGE_W-1:0]       frame_page,
	output logic [pft_pkg::COUNT_W-1:0]      free_frames
);

	localparam int unsigned AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam logic [8:0] FRAMES_V = 9'(FRAMES);

	function automatic logic [pft_pkg::COUNT_W-1:0] clamp_cnt(
		input logic [pft_pkg::COUNT_W-1:0] v
	);
		logic [pft_pkg::COUNT_W-1:0] r;
		if (v == '0) begin
			r = pft_pkg::COUNT_W'(1);
		end else if ({2'b00, v} > FRAMES_V) begin
			r = FRAMES_V[pft_pkg::COUNT_W-1:0];
		end else begin
			r = v;
		end
		return r;
	endfunction

	pft_pkg::ctl_state_t state_q, state_d;

	logic [pft_pkg::COUNT_W-1:0] fiu_q;
	logic [pft_pkg::COUNT_W-1:0] free_cnt_q;
	logic [pft_pkg::COUNT_W-1:0] active_cnt;
	logic [FRAMES-1:0]           occ_q;

	logic [2:0]                   op_s1;
	logic [pft_pkg::FRAME_IDX_W-1:0] idx_s1;
	logic [pft_pkg::OWNER_W-1:0]  owner_s1;
	logic [pft_pkg::PAGE_W-1:0]   page_s1;
	logic                         wr_s1;

	logic                   cfg_wr;
	logic                   in_acc;
	logic                   issue;
	logic                   in_range;
	logic                   occ_at;
	logic [AW-1:0]          idx_a;
	logic [AW-1:0]          chosen_a;
	pft_pkg::search_res_t   srch;
	pft_pkg::entry_t        rd_entry;

	// decision results
	logic                   mem_wen;
	logic [AW-1:0]          mem_waddr;
	pft_pkg::entry_t        mem_wdata;
	pft_pkg::status_t       st_d;
	logic [pft_pkg::CHOSEN_W-1:0] chosen_d;
	logic                   r_occ_d, r_dirty_d, r_ref_d;
	logic [pft_pkg::OWNER_W-1:0] r_owner_d;
	logic [pft_pkg::PAGE_W-1:0]  r_page_d;
	logic                   set_occ, clr_occ;
	logic [AW-1:0]          upd_a;
	logic                   free_dec, free_inc;

	// output register
	logic                   out_valid_q;
	logic [pft_pkg::STATUS_W-1:0] status_q;
	logic [pft_pkg::CHOSEN_W-1:0] chosen_q;
	logic                   occ_out_q, dirty_out_q, ref_out_q;
	logic [pft_pkg::OWNER_W-1:0] owner_out_q;
	logic [pft_pkg::PAGE_W-1:0]  page_out_q;
	logic [pft_pkg::COUNT_W-1:0] free_out_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? {25'd0, fiu_q} : 32'd0;

	assign active_cnt = clamp_cnt(fiu_q);

	// handshakes
	assign in_ready = (state_q == pft_pkg::CTL_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign issue    = (state_q == pft_pkg::CTL_EXEC) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pft_pkg::CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pft_pkg::CTL_IDLE: begin
				if (in_acc) begin
					state_d = pft_pkg::CTL_EXEC;
				end
			end
			pft_pkg::CTL_EXEC: begin
				if (issue) begin
					state_d = pft_pkg::CTL_IDLE;
				end
			end
			default: state_d = pft_pkg::CTL_IDLE;
		endcase
	end

	// hold the item for the decision cycle
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1    <= operation;
			idx_s1   <= frame_index;
			owner_s1 <= owner_id;
			page_s1  <= page_number;
			wr_s1    <= write_access;
		end
	end

	pft_frame_ram #(
		.DEPTH (FRAMES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.wen   (mem_wen),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.ren   (in_acc),
		.raddr (frame_index[AW-1:0]),
		.rdata (rd_entry)
	);

	pft_free_search #(
		.FRAMES (FRAMES)
	) u_search (
		.clk    (clk),
		.load   (in_acc),
		.occ    (occ_q),
		.count  (active_cnt),
		.result (srch)
	);

	assign idx_a    = idx_s1[AW-1:0];
	assign chosen_a = srch.index[AW-1:0];
	assign in_range = {1'b0, idx_s1} < {2'b00, active_cnt};
	assign occ_at   = in_range && occ_q[idx_a];

	always_comb begin
		st_d      = pft_pkg::STAT_OK;
		chosen_d  = '0;
		r_occ_d   = 1'b0;
		r_dirty_d = 1'b0;
		r_ref_d   = 1'b0;
		r_owner_d = '1;
		r_page_d  = '0;
		mem_wen   = 1'b0;
		mem_waddr = idx_a;
		mem_wdata.owner      = owner_s1;
		mem_wdata.page       = page_s1;
		mem_wdata.dirty      = 1'b0;
		mem_wdata.referenced = 1'b0;
		set_occ   = 1'b0;
		clr_occ   = 1'b0;
		upd_a     = idx_a;
		free_dec  = 1'b0;
		free_inc  = 1'b0;
		case (op_s1)
			pft_pkg::OP_ALLOC: begin
				if (owner_s1[pft_pkg::OWNER_W-1]) begin
					st_d = pft_pkg::STAT_INVALID;
				end else if (!srch.found) begin
					st_d = pft_pkg::STAT_FULL;
				end else begin
					chosen_d  = pft_pkg::CHOSEN_W'(srch.index);
					mem_wen   = 1'b1;
					mem_waddr = chosen_a;
					upd_a     = chosen_a;
					set_occ   = 1'b1;
					free_dec  = 1'b1;
				end
			end
			pft_pkg::OP_REPLACE: begin
				if (owner_s1[pft_pkg::OWNER_W-1] || !occ_at) begin
					st_d = pft_pkg::STAT_INVALID;
				end else begin
					mem_wen = 1'b1;
				end
			end
			pft_pkg::OP_RELEASE: begin
				if (!occ_at) begin
					st_d = pft_pkg::STAT_INVALID;
				end else begin
					clr_occ  = 1'b1;
					free_inc = 1'b1;
				end
			end
			pft_pkg::OP_MARK: begin
				if (!occ_at) begin
					st_d = pft_pkg::STAT_INVALID;
				end else begin
					mem_wen              = 1'b1;
					mem_wdata.owner      = rd_entry.owner;
					mem_wdata.page       = rd_entry.page;
					mem_wdata.dirty      = rd_entry.dirty | wr_s1;
					mem_wdata.referenced = 1'b1;
				end
			end
			pft_pkg::OP_READ: begin
				if (!in_range) begin
					st_d = pft_pkg::STAT_INVALID;
				end else begin
					r_occ_d = occ_at;
					if (occ_at) begin
						r_dirty_d = rd_entry.dirty;
						r_ref_d   = rd_entry.referenced;
						r_owner_d = rd_entry.owner;
						r_page_d  = rd_entry.page;
					end
				end
			end
			default: st_d = pft_pkg::STAT_INVALID;
		endcase
		if (!issue) begin
			mem_wen = 1'b0;
		end
	end

	// occupied marks and free count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q      <= pft_pkg::COUNT_W'(64);
			free_cnt_q <= clamp_cnt(pft_pkg::COUNT_W'(64));
			occ_q      <= '0;
		end else if (cfg_wr) begin
			fiu_q      <= pwdata[pft_pkg::COUNT_W-1:0];
			free_cnt_q <= clamp_cnt(pwdata[pft_pkg::COUNT_W-1:0]);
			occ_q      <= '0;
		end else if (issue) begin
			if (set_occ) begin
				occ_q[upd_a] <= 1'b1;
			end
			if (clr_occ) begin
				occ_q[upd_a] <= 1'b0;
			end
			if (free_dec) begin
				free_cnt_q <= free_cnt_q - pft_pkg::COUNT_W'(1);
			end else if (free_inc) begin
				free_cnt_q <= free_cnt_q + pft_pkg::COUNT_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (issue) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			status_q    <= st_d;
			chosen_q    <= chosen_d;
			occ_out_q   <= r_occ_d;
			dirty_out_q <= r_dirty_d;
			ref_out_q   <= r_ref_d;
			owner_out_q <= r_owner_d;
			page_out_q  <= r_page_d;
			free_out_q  <= free_dec ? free_cnt_q - pft_pkg::COUNT_W'(1) :
				(free_inc ? free_cnt_q + pft_pkg::COUNT_W'(1) : free_cnt_q);
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign chosen_frame     = chosen_q;
	assign frame_occupied   = occ_out_q;
	assign frame_dirty      = dirty_out_q;
	assign frame_referenced = ref_out_q;
	assign frame_owner      = owner_out_q;
	assign frame_page       = page_out_q;
	assign free_frames      = free_out_q;

	a_free_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(free_cnt_q) + $countones(occ_q)) == int'(active_cnt))
		else $error("free count does not match occupied frames");

	a_free_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= active_cnt)
		else $error("free count above managed frame count");

	a_alloc_takes_free: assert property (@(posedge clk) disable iff (!arst_n)
		issue && set_occ |-> !occ_q[upd_a] && srch.found)
		else $error("allocate took an occupied frame");

	a_accept_starts_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == pft_pkg::CTL_EXEC && !in_ready)
		else $error("accepted item did not enter decision cycle");

endmodule

// ----- tb/sv/physical_frame_table_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for physical_frame_table: directed and random items
// checked against a frame table predictor kept in a scoreboard class.
// Depends on pft_pkg and the physical_frame_table RTL.
module physical_frame_table_test;

	localparam int unsigned FRAMES = 64;
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned REPORT_CAP = 100;
	localparam logic [2:0] ADDR_FRAMES_IN_USE = 3'd0;
	localparam logic [2:0] OP_UNKNOWN_FIRST = 3'd5;
	localparam logic [2:0] OP_UNKNOWN_LAST = 3'd7;
	localparam logic [pft_pkg::PAGE_W-1:0] PAGE_ALL = '1;
	localparam logic signed [pft_pkg::OWNER_W-1:0] OWNER_MAX = 16'sh7FFF;
	localparam logic signed [pft_pkg::OWNER_W-1:0] OWNER_MIN = 16'sh8000;
	localparam logic signed [pft_pkg::OWNER_W-1:0] OWNER_NONE = -16'sd1;

	typedef struct {
		logic [2:0]                         op;
		logic [pft_pkg::FRAME_IDX_W-1:0]    idx;
		logic signed [pft_pkg::OWNER_W-1:0] owner;
		logic [pft_pkg::PAGE_W-1:0]         page;
		logic                               wr;
	} frame_request_t;

	typedef struct {
		pft_pkg::status_t                   status;
		logic [pft_pkg::CHOSEN_W-1:0]       chosen;
		logic                               occupied;
		logic                               dirty;
		logic                               referenced;
		logic signed [pft_pkg::OWNER_W-1:0] owner;
		logic [pft_pkg::PAGE_W-1:0]         page;
		logic [pft_pkg::COUNT_W-1:0]        free;
	} frame_result_t;

	class frame_table_scoreboard;
		bit                                 occupied_map[FRAMES];
		bit                                 dirty_map[FRAMES];
		bit                                 referenced_map[FRAMES];
		logic signed [pft_pkg::OWNER_W-1:0] owner_map[FRAMES];
		logic [pft_pkg::PAGE_W-1:0]         page_map[FRAMES];
		logic [pft_pkg::COUNT_W-1:0]        free_count;
		logic [pft_pkg::COUNT_W-1:0]        frame_count_reg;
		frame_result_t                      pending[$];
		int unsigned                        accepted;
		int unsigned                        results;
		int unsigned                        errors;

		function new();
			accepted = 0;
			results = 0;
			errors = 0;
			set_frame_count(7'd64);
		endfunction

		function int unsigned managed();
			if (frame_count_reg < 1)
				return 1;
			if (frame_count_reg > FRAMES)
				return FRAMES;
			return frame_count_reg;
		endfunction

		function void clear_frame(int unsigned f);
			occupied_map[f] = 0;
			dirty_map[f] = 0;
			referenced_map[f] = 0;
			owner_map[f] = OWNER_NONE;
			page_map[f] = '0;
		endfunction

		function void take_frame(int unsigned f,
				logic signed [pft_pkg::OWNER_W-1:0] owner,
				logic [pft_pkg::PAGE_W-1:0] page);
			occupied_map[f] = 1;
			dirty_map[f] = 0;
			referenced_map[f] = 0;
			owner_map[f] = owner;
			page_map[f] = page;
		endfunction

		function void set_frame_count(logic [pft_pkg::COUNT_W-1:0] value);
			frame_count_reg = value;
			for (int f = 0; f < FRAMES; f++)
				clear_frame(f);
			free_count = pft_pkg::COUNT_W'(managed());
		endfunction

		function int pick_occupied();
			int hits[$];
			for (int f = 0; f < managed(); f++)
				if (occupied_map[f])
					hits.push_back(f);
			if (hits.size() == 0)
				return -1;
			return hits[$urandom_range(0, hits.size() - 1)];
		endfunction

		function void note_request(frame_request_t rq);
			frame_result_t r;
			int unsigned n;
			bit in_range;
			bit found;
			n = managed();
			in_range = rq.idx < n;
			r.status = pft_pkg::STAT_OK;
			r.chosen = '0;
			r.occupied = 0;
			r.dirty = 0;
			r.referenced = 0;
			r.owner = OWNER_NONE;
			r.page = '0;
			case (rq.op)
				pft_pkg::OP_ALLOC: begin
					if (rq.owner < 0) begin
						r.status = pft_pkg::STAT_INVALID;
					end else if (free_count == 0) begin
						r.status = pft_pkg::STAT_FULL;
					end else begin
						r.status = pft_pkg::STAT_FULL;
						found = 0;
						for (int f = 0; f < n && !found; f++) begin
							if (!occupied_map[f]) begin
								take_frame(f, rq.owner, rq.page);
								free_count--;
								r.chosen = pft_pkg::CHOSEN_W'(f);
								r.status = pft_pkg::STAT_OK;
								found = 1;
							end
						end
					end
				end
				pft_pkg::OP_REPLACE: begin
					if (rq.owner < 0 || !in_range || !occupied_map[rq.idx])
						r.status = pft_pkg::STAT_INVALID;
					else
						take_frame(rq.idx, rq.owner, rq.page);
				end
				pft_pkg::OP_RELEASE: begin
					if (!in_range || !occupied_map[rq.idx]) begin
						r.status = pft_pkg::STAT_INVALID;
					end else begin
						clear_frame(rq.idx);
						free_count++;
					end
				end
				pft_pkg::OP_MARK: begin
					if (!in_range || !occupied_map[rq.idx]) begin
						r.status = pft_pkg::STAT_INVALID;
					end else begin
						referenced_map[rq.idx] = 1;
						if (rq.wr)
							dirty_map[rq.idx] = 1;
					end
				end
				pft_pkg::OP_READ: begin
					if (!in_range) begin
						r.status = pft_pkg::STAT_INVALID;
					end else begin
						r.occupied = occupied_map[rq.idx];
						r.dirty = dirty_map[rq.idx];
						r.referenced = referenced_map[rq.idx];
						r.owner = owner_map[rq.idx];
						r.page = page_map[rq.idx];
					end
				end
				default: r.status = pft_pkg::STAT_INVALID;
			endcase
			r.free = free_count;
			pending.push_back(r);
			accepted++;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= REPORT_CAP)
				$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task check_result(frame_result_t got);
			frame_result_t want;
			results++;
			if (pending.size() == 0) begin
				report($sformatf("result %0d arrived with no item pending", results));
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status)
				report($sformatf("result %0d status %0d, want %0d",
					results, got.status, want.status));
			if (got.chosen !== want.chosen)
				report($sformatf("result %0d chosen_frame %0d, want %0d",
					results, got.chosen, want.chosen));
			if (got.occupied !== want.occupied)
				report($sformatf("result %0d frame_occupied %b, want %b",
					results, got.occupied, want.occupied));
			if (got.dirty !== want.dirty)
				report($sformatf("result %0d frame_dirty %b, want %b",
					results, got.dirty, want.dirty));
			if (got.referenced !== want.referenced)
				report($sformatf("result %0d frame_referenced %b, want %b",
					results, got.referenced, want.referenced));
			if (got.owner !== want.owner)
				report($sformatf("result %0d frame_owner %0d, want %0d",
					results, got.owner, want.owner));
			if (got.page !== want.page)
				report($sformatf("result %0d frame_page %h, want %h",
					results, got.page, want.page));
			if (got.free !== want.free)
				report($sformatf("result %0d free_frames %0d, want %0d",
					results, got.free, want.free));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	wire [31:0] prdata;
	wire pready;
	logic in_valid = 1'b0;
	wire in_ready;
	logic [2:0] operation = '0;
	logic [pft_pkg::FRAME_IDX_W-1:0] frame_index = '0;
	logic signed [pft_pkg::OWNER_W-1:0] owner_id = '0;
	logic [pft_pkg::PAGE_W-1:0] page_number = '0;
	logic write_access = 1'b0;
	wire out_valid;
	logic out_ready = 1'b0;
	wire [pft_pkg::STATUS_W-1:0] status;
	wire [pft_pkg::CHOSEN_W-1:0] chosen_frame;
	wire frame_occupied;
	wire frame_dirty;
	wire frame_referenced;
	wire signed [pft_pkg::OWNER_W-1:0] frame_owner;
	wire [pft_pkg::PAGE_W-1:0] frame_page;
	wire [pft_pkg::COUNT_W-1:0] free_frames;

	frame_table_scoreboard sb = new();
	bit steady = 1'b0;

	physical_frame_table #(.FRAMES(FRAMES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.frame_index(frame_index),
		.owner_id(owner_id),
		.page_number(page_number),
		.write_access(write_access),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.chosen_frame(chosen_frame),
		.frame_occupied(frame_occupied),
		.frame_dirty(frame_dirty),
		.frame_referenced(frame_referenced),
		.frame_owner(frame_owner),
		.frame_page(frame_page),
		.free_frames(free_frames)
	);

	always #5 clk = ~clk;

	task automatic send(input frame_request_t rq);
		if (!steady && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= rq.op;
		frame_index <= rq.idx;
		owner_id <= rq.owner;
		page_number <= rq.page;
		write_access <= rq.wr;
		do @(posedge clk); while (!in_ready);
		sb.note_request(rq);
	endtask

	task automatic issue(input logic [2:0] op,
			input logic [pft_pkg::FRAME_IDX_W-1:0] idx,
			input logic signed [pft_pkg::OWNER_W-1:0] owner,
			input logic [pft_pkg::PAGE_W-1:0] page,
			input logic wr);
		frame_request_t rq;
		rq.op = op;
		rq.idx = idx;
		rq.owner = owner;
		rq.page = page;
		rq.wr = wr;
		send(rq);
	endtask

	// drop valid, wait for every pending result, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_frame_count(input logic [pft_pkg::COUNT_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_FRAMES_IN_USE;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_frame_count(value);
	endtask

	function automatic frame_request_t random_request(int unsigned alloc_pct);
		frame_request_t rq;
		int unsigned roll;
		int unsigned n;
		int occ;
		n = sb.managed();
		roll = $urandom_range(0, 99);
		if (roll < alloc_pct) begin
			rq.op = pft_pkg::OP_ALLOC;
		end else if (roll >= 96) begin
			rq.op = 3'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST));
		end else begin
			case ($urandom_range(0, 3))
				0: rq.op = pft_pkg::OP_REPLACE;
				1: rq.op = pft_pkg::OP_RELEASE;
				2: rq.op = pft_pkg::OP_MARK;
				default: rq.op = pft_pkg::OP_READ;
			endcase
		end
		roll = $urandom_range(0, 9);
		occ = sb.pick_occupied();
		if (roll < 7 && occ >= 0)
			rq.idx = pft_pkg::FRAME_IDX_W'(occ);
		else if (roll < 9)
			rq.idx = pft_pkg::FRAME_IDX_W'($urandom_range(0, n - 1));
		else
			rq.idx = pft_pkg::FRAME_IDX_W'($urandom_range(0, 255));
		roll = $urandom_range(0, 19);
		rq.owner = pft_pkg::OWNER_W'($urandom);
		if (roll == 1)
			rq.owner = $urandom_range(0, 1) ? OWNER_MAX : OWNER_MIN;
		else if (roll > 1)
			rq.owner[pft_pkg::OWNER_W-1] = 1'b0;
		rq.page = pft_pkg::PAGE_W'({$urandom, $urandom});
		rq.wr = 1'($urandom_range(0, 1));
		return rq;
	endfunction

	task automatic run_random(input logic [pft_pkg::COUNT_W-1:0] count_value,
			input int unsigned items, input int unsigned alloc_pct,
			input bit quiet_tail);
		settle();
		write_frame_count(count_value);
		for (int i = 0; i < items; i++) begin
			if (quiet_tail && i + 100 >= items)
				steady = 1'b1;
			send(random_request(alloc_pct));
		end
	endtask

	initial begin : sink
		frame_result_t got;
		int unsigned stall_left;
		bit held;
		stall_left = 0;
		held = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.status = pft_pkg::status_t'(status);
				got.chosen = chosen_frame;
				got.occupied = frame_occupied;
				got.dirty = frame_dirty;
				got.referenced = frame_referenced;
				got.owner = frame_owner;
				got.page = frame_page;
				got.free = free_frames;
				sb.check_result(got);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!held && sb.accepted >= 300) begin
				// hold off long enough for the block to back up into its input
				held = 1;
				stall_left = 59;
				out_ready <= 1'b0;
			end else if (!steady && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 11);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("physical_frame_table_test NOT OK");
		$finish;
	end

	initial begin : stimulus
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full table of 64 frames after reset
		issue(pft_pkg::OP_READ, 8'd0, 16'sd0, '0, 1'b0);
		issue(pft_pkg::OP_ALLOC, 8'd0, 16'sd0, '0, 1'b0);
		issue(pft_pkg::OP_ALLOC, 8'd0, OWNER_MAX, PAGE_ALL, 1'b1);
		issue(pft_pkg::OP_ALLOC, 8'd0, OWNER_MIN, 52'h1234, 1'b0);
		issue(pft_pkg::OP_ALLOC, 8'd0, OWNER_NONE, 52'h1234, 1'b0);
		issue(pft_pkg::OP_REPLACE, 8'd1, -16'sd5, 52'h55, 1'b0);
		issue(pft_pkg::OP_REPLACE, 8'd0, 16'sd12, 52'hABCDE_F012_3456, 1'b0);
		issue(pft_pkg::OP_REPLACE, 8'd5, 16'sd3, 52'h77, 1'b0);
		issue(pft_pkg::OP_REPLACE, 8'd200, 16'sd3, 52'h77, 1'b0);
		issue(pft_pkg::OP_MARK, 8'd0, 16'sd0, '0, 1'b1);
		issue(pft_pkg::OP_MARK, 8'd1, 16'sd0, '0, 1'b0);
		issue(pft_pkg::OP_MARK, 8'd3, 16'sd0, '0, 1'b1);
		issue(pft_pkg::OP_MARK, 8'd255, 16'sd0, '0, 1'b1);
		issue(pft_pkg::OP_READ, 8'd0, 16'sd0, '0, 1'b0);
		issue(pft_pkg::OP_READ, 8'd1, 16'sd0, '0, 1'b0);
		issue(pft_pkg::OP_READ, 8'd64, 16'sd0, '0, 1'b0);
		issue(pft_pkg::OP_READ, 8'd255, OWNER_NONE, PAGE_ALL, 1'b1);
		issue(pft_pkg::OP_RELEASE, 8'd0, 16'sd0, '0, 1'b0);
		issue(pft_pkg::OP_RELEASE, 8'd0, 16'sd0, '0, 1'b0);
		issue(pft_pkg::OP_RELEASE, 8'd255, 16'sd0, '0, 1'b0);
		for (int c = OP_UNKNOWN_FIRST; c <= OP_UNKNOWN_LAST; c++)
			issue(3'(c), 8'd1, 16'sd9, 52'h9, 1'b1);
		issue(pft_pkg::OP_ALLOC, 8'd0, 16'sd21, 52'h2_1000, 1'b0);
		issue(pft_pkg::OP_READ, 8'd63, 16'sd0, '0, 1'b0);

		// single frame: fill it, then full and owner checks
		settle();
		write_frame_count(7'd1);
		issue(pft_pkg::OP_ALLOC, 8'd0, 16'sd7, 52'h7, 1'b0);
		issue(pft_pkg::OP_ALLOC, 8'd0, 16'sd5, 52'h5, 1'b0);
		issue(pft_pkg::OP_ALLOC, 8'd0, OWNER_NONE, 52'h5, 1'b0);
		issue(pft_pkg::OP_READ, 8'd1, 16'sd0, '0, 1'b0);
		issue(pft_pkg::OP_MARK, 8'd0, 16'sd0, '0, 1'b1);
		issue(pft_pkg::OP_READ, 8'd0, 16'sd0, '0, 1'b0);
		issue(pft_pkg::OP_RELEASE, 8'd0, 16'sd0, '0, 1'b0);
		issue(pft_pkg::OP_READ, 8'd0, 16'sd0, '0, 1'b0);
		issue(pft_pkg::OP_ALLOC, 8'd0, 16'sd8, 52'h8, 1'b0);

		run_random(7'd0, 30, 40, 1'b0);
		run_random(7'd127, 150, 70, 1'b0);
		run_random(7'd5, 120, 35, 1'b0);
		run_random(7'd64, 150, 40, 1'b0);
		run_random(7'd33, 150, 45, 1'b1);

		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		if (sb.errors == 0)
			$display("physical_frame_table_test OK");
		else
			$display("physical_frame_table_test NOT OK");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/pft_pkg.sv
rtl/pft_frame_ram.sv
rtl/pft_free_search.sv
rtl/physical_frame_table.sv
tb/sv/physical_frame_table_test.sv
